// ===== design/htsed_pkg.sv =====
// ----------------------------------------------------------------------------
// htsed_pkg: shared types and constants
// Transaction types, controller commands and status, and the entity name table
// with its lookup function.
// ----------------------------------------------------------------------------
package htsed_pkg;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       byte_valid;
		logic       end_of_text;
	} text_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       last_result;
	} clean_item_t;

	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
	localparam logic [OP_W-1:0] OP_IN     = 3'd1;
	localparam logic [OP_W-1:0] OP_RP     = 3'd2;
	localparam logic [OP_W-1:0] OP_FFAIL  = 3'd3;
	localparam logic [OP_W-1:0] OP_FINISH = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            hold_mode;
	} cmd_t;

	typedef struct packed {
		logic fail;
		logic ent;
		logic rp_empty;
		logic rp_one;
		logic can_emit;
	} stat_t;

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_QUOT  = 8'h22;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DASH  = 8'h2d;
	localparam logic [7:0] CH_QMARK = 8'h3f;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_LT    = 8'h3c;
	localparam logic [7:0] CH_GT    = 8'h3e;

	localparam int NUM_NAMES  = 13;
	localparam int NAME_CHARS = 5;
	localparam int NAME_W     = 8 * NAME_CHARS;
	localparam int LEN_W      = 4;

	// first character in the low byte
	localparam logic [NAME_W-1:0] ENT_NAME [NUM_NAMES] = '{
		40'h00_00_70_6d_61,	// amp
		40'h00_00_38_33_23,	// #38
		40'h00_00_39_33_23,	// #39
		40'h00_73_6f_70_61,	// apos
		40'h6f_75_71_73_72,	// rsquo
		40'h6f_75_71_73_6c,	// lsquo
		40'h00_74_6f_75_71,	// quot
		40'h6f_75_71_64_6c,	// ldquo
		40'h6f_75_71_64_72,	// rdquo
		40'h00_70_73_62_6e,	// nbsp
		40'h68_73_61_64_6d,	// mdash
		40'h68_73_61_64_6e,	// ndash
		40'h37_31_32_38_23	// #8217
	};

	localparam logic [LEN_W-1:0] ENT_LEN [NUM_NAMES] = '{
		4'd3, 4'd3, 4'd3, 4'd4, 4'd5, 4'd5, 4'd4, 4'd5, 4'd5, 4'd4, 4'd5, 4'd5, 4'd5
	};

	localparam logic [7:0] ENT_CHAR [NUM_NAMES] = '{
		CH_AMP, CH_AMP, CH_APOS, CH_APOS, CH_APOS, CH_APOS, CH_QUOT, CH_QUOT, CH_QUOT,
		CH_SPACE, CH_DASH, CH_DASH, CH_APOS
	};

	function automatic logic [7:0] ent_lookup(input logic [NAME_W-1:0] name,
		input logic [LEN_W-1:0] len);
		logic [7:0]        ch;
		logic [NAME_W-1:0] mask;
		ch = CH_QMARK;
		for (int i = 0; i < NUM_NAMES; i++) begin
			mask = {NAME_W{1'b1}} >> (8 * (NAME_CHARS - int'(ENT_LEN[i])));
			if (len == ENT_LEN[i] && (name & mask) == (ENT_NAME[i] & mask)) begin
				ch = ENT_CHAR[i];
			end
		end
		return ch;
	endfunction

endpackage

// ===== design/htsed_dp.sv =====
// ----------------------------------------------------------------------------
// htsed_dp: byte datapath
// One byte step per command: tag and entity tracking, lookahead and replay
// buffers, end-of-text hold stage and the output register.
// ----------------------------------------------------------------------------
module htsed_dp #(
	parameter int MAX_ENTITY_SPAN = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  htsed_pkg::text_item_t  text,
	input  htsed_pkg::cmd_t        cmd,
	input  logic                   clean_ready,
	output htsed_pkg::stat_t       st,
	output logic                   clean_valid,
	output htsed_pkg::clean_item_t clean
);

	localparam int IDXW = $clog2(MAX_ENTITY_SPAN);
	localparam int CNTW = $clog2(MAX_ENTITY_SPAN + 1);

	logic [7:0]                     la_q [MAX_ENTITY_SPAN];
	logic [7:0]                     la_d [MAX_ENTITY_SPAN];
	logic [7:0]                     rp_q [MAX_ENTITY_SPAN];
	logic [CNTW-1:0]                cnt_q, cnt_d;
	logic [CNTW-1:0]                rp_cnt_q, rp_len;
	logic                           ent_q, ent_d;
	logic                           tag_q, tag_d;
	logic [7:0]                     hold_byte_q;
	logic                           hold_v_q;
	logic                           clean_v_q;
	htsed_pkg::clean_item_t         clean_q;
	logic [7:0]                     b;
	logic                           proc;
	logic                           fail;
	logic                           emit;
	logic [7:0]                     emit_byte;
	logic [htsed_pkg::NAME_W-1:0]   name;
	logic                           push;
	htsed_pkg::clean_item_t         push_item;
	logic                           can_emit;

	assign can_emit    = !clean_v_q || clean_ready;
	assign clean_valid = clean_v_q;
	assign clean       = clean_q;

	always_comb begin
		for (int j = 0; j < htsed_pkg::NAME_CHARS; j++) begin
			name[8*j +: 8] = la_q[j];
		end
	end

	always_comb begin
		b         = (cmd.op == htsed_pkg::OP_RP) ? rp_q[0] : text.text_byte;
		proc      = (cmd.op == htsed_pkg::OP_IN && text.byte_valid) ||
			(cmd.op == htsed_pkg::OP_RP);
		la_d      = la_q;
		cnt_d     = cnt_q;
		ent_d     = ent_q;
		tag_d     = tag_q;
		emit      = 1'b0;
		emit_byte = b;
		fail      = 1'b0;
		rp_len    = cnt_q;
		if (proc) begin
			if (ent_q) begin
				if (b == htsed_pkg::CH_SEMI) begin
					emit      = 1'b1;
					emit_byte = htsed_pkg::ent_lookup(name, htsed_pkg::LEN_W'(cnt_q));
					ent_d     = 1'b0;
					cnt_d     = '0;
				end else begin
					la_d[cnt_q[IDXW-1:0]] = b;
					cnt_d = cnt_q + 1'b1;
					if (cnt_d == CNTW'(MAX_ENTITY_SPAN)) begin
						fail   = 1'b1;
						rp_len = cnt_d;
					end
				end
			end else if (tag_q) begin
				if (b == htsed_pkg::CH_GT) begin
					tag_d = 1'b0;
				end
			end else if (b == htsed_pkg::CH_LT) begin
				tag_d = 1'b1;
			end else if (b == htsed_pkg::CH_AMP) begin
				ent_d = 1'b1;
				cnt_d = '0;
			end else begin
				emit = 1'b1;
			end
		end
		if (cmd.op == htsed_pkg::OP_FFAIL) begin
			fail = 1'b1;
		end
		if (fail) begin
			emit      = 1'b1;
			emit_byte = htsed_pkg::CH_AMP;
			ent_d     = 1'b0;
			cnt_d     = '0;
		end
		if (cmd.op == htsed_pkg::OP_FINISH) begin
			ent_d = 1'b0;
			tag_d = 1'b0;
			cnt_d = '0;
		end
	end

	// in hold mode a new result pushes the held one out
	always_comb begin
		push                  = 1'b0;
		push_item.out_byte    = hold_byte_q;
		push_item.out_valid   = 1'b1;
		push_item.last_result = 1'b0;
		if (cmd.op == htsed_pkg::OP_FINISH) begin
			push                  = 1'b1;
			push_item.out_byte    = hold_v_q ? hold_byte_q : 8'h00;
			push_item.out_valid   = hold_v_q;
			push_item.last_result = 1'b1;
		end else if (emit) begin
			if (!cmd.hold_mode) begin
				push               = 1'b1;
				push_item.out_byte = emit_byte;
			end else if (hold_v_q) begin
				push = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			ent_q     <= 1'b0;
			tag_q     <= 1'b0;
			rp_cnt_q  <= '0;
			hold_v_q  <= 1'b0;
			clean_v_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			ent_q <= ent_d;
			tag_q <= tag_d;
			if (fail) begin
				rp_cnt_q <= rp_len;
			end else if (cmd.op == htsed_pkg::OP_RP) begin
				rp_cnt_q <= rp_cnt_q - 1'b1;
			end
			if (cmd.op == htsed_pkg::OP_FINISH) begin
				hold_v_q <= 1'b0;
			end else if (emit && cmd.hold_mode) begin
				hold_v_q <= 1'b1;
			end
			if (push) begin
				clean_v_q <= 1'b1;
			end else if (clean_ready) begin
				clean_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		la_q <= la_d;
		if (fail) begin
			rp_q <= la_d;
		end else if (cmd.op == htsed_pkg::OP_RP) begin
			for (int i = 0; i < MAX_ENTITY_SPAN - 1; i++) begin
				rp_q[i] <= rp_q[i+1];
			end
		end
		if (emit && cmd.hold_mode) begin
			hold_byte_q <= emit_byte;
		end
		if (push) begin
			clean_q <= push_item;
		end
	end

	assign st.fail     = fail;
	assign st.ent      = ent_q;
	assign st.rp_empty = (rp_cnt_q == '0);
	assign st.rp_one   = (rp_cnt_q == CNTW'(1));
	assign st.can_emit = can_emit;

endmodule

// ===== design/htsed_ctrl.sv =====
// ----------------------------------------------------------------------------
// htsed_ctrl: sequencing controller
// Accepts transactions, runs the replay of a failed entity and the
// end-of-text flush, one datapath step per cycle while the output can take it.
// ----------------------------------------------------------------------------
module htsed_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             text_valid,
	input  logic             end_of_text,
	input  htsed_pkg::stat_t st,
	output logic             text_ready,
	output htsed_pkg::cmd_t  cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_REPLAY = 2'd1;
	localparam logic [1:0] S_FLUSH  = 2'd2;

	logic [1:0] state_q, state_d;
	logic       flush_q, flush_d;

	always_comb begin
		state_d       = state_q;
		flush_d       = flush_q;
		cmd.op        = htsed_pkg::OP_NONE;
		cmd.hold_mode = flush_q;
		text_ready    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				text_ready    = st.can_emit;
				cmd.hold_mode = end_of_text;
				if (text_valid && st.can_emit) begin
					cmd.op  = htsed_pkg::OP_IN;
					flush_d = end_of_text;
					if (st.fail) begin
						state_d = S_REPLAY;
					end else if (end_of_text) begin
						state_d = S_FLUSH;
					end
				end
			end
			S_REPLAY: begin
				if (st.rp_empty) begin
					state_d = flush_q ? S_FLUSH : S_IDLE;
				end else if (st.can_emit) begin
					cmd.op = htsed_pkg::OP_RP;
					if (st.rp_one) begin
						state_d = flush_q ? S_FLUSH : S_IDLE;
					end
				end
			end
			S_FLUSH: begin
				if (st.can_emit) begin
					if (st.ent) begin
						cmd.op  = htsed_pkg::OP_FFAIL;
						state_d = S_REPLAY;
					end else begin
						cmd.op  = htsed_pkg::OP_FINISH;
						flush_d = 1'b0;
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			flush_q <= 1'b0;
		end else begin
			state_q <= state_d;
			flush_q <= flush_d;
		end
	end

endmodule

// ===== design/html_tag_strip_entity_decode.sv =====
// Output: each result is registered into the output register by the step that makes it; results
// of an end-of-text transaction wait in the hold stage for the next result, the last one for the
// closing flush step. Throughput: one byte per cycle while the output can take a result; an
// entity that fails at the span limit is replayed byte by byte, and end of text adds a flush
// step plus a forced fail and a replay of the held bytes per pending entity. The replay loop sets this.
// Reset: arst_n clears the control and valid state; lookahead, replay, held and output bytes are not cleared.
// ----------------------------------------------------------------------------
// html_tag_strip_entity_decode: HTML tag stripper and entity decoder
// Drops markup between '<' and '>', decodes named and numeric entities and
// marks the last result of each text.
// ----------------------------------------------------------------------------
module html_tag_strip_entity_decode #(
	parameter int MAX_ENTITY_SPAN = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   text_valid,
	output logic                   text_ready,
	input  htsed_pkg::text_item_t  text,
	output logic                   clean_valid,
	input  logic                   clean_ready,
	output htsed_pkg::clean_item_t clean
);

	htsed_pkg::cmd_t  cmd;
	htsed_pkg::stat_t st;

	htsed_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_valid  (text_valid),
		.end_of_text (text.end_of_text),
		.st          (st),
		.text_ready  (text_ready),
		.cmd         (cmd)
	);

	htsed_dp #(
		.MAX_ENTITY_SPAN (MAX_ENTITY_SPAN)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.text        (text),
		.cmd         (cmd),
		.clean_ready (clean_ready),
		.st          (st),
		.clean_valid (clean_valid),
		.clean       (clean)
	);

	a_no_fail_in_replay: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == htsed_pkg::OP_RP |-> !st.fail)
		else $error("entity failed during replay");

	a_fail_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		st.fail |=> !text_ready)
		else $error("input taken right after entity failure");

	a_empty_marker: assert property (@(posedge clk) disable iff (!arst_n)
		clean_valid && !clean.out_valid |-> clean.last_result && clean.out_byte == 8'h00)
		else $error("empty result is not a clean end marker");

	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == htsed_pkg::OP_FINISH |=> !st.ent && st.rp_empty)
		else $error("state left after flush");

endmodule

// ===== test/html_tag_strip_entity_decode_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// html_tag_strip_entity_decode_test: self-checking bench for the tag stripper
// A short directed table, then random texts; both sides idle at random in the
// first two phases. Each cleaned transaction is checked against the typed row
// result or a local decoder that holds its own entity and tag state.
// ----------------------------------------------------------------------------
module html_tag_strip_entity_decode_test;

	localparam int SPAN = 8;
	localparam int NUM_ENTITIES = 13;

	typedef struct packed {
		logic [7:0] b;
		logic       v;
		logic       e;
		logic       typed;
		logic [7:0] wb;
		logic       wv;
		logic       wl;
	} dir_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   text_valid = 1'b0;
	logic                   text_ready;
	htsed_pkg::text_item_t  text = '0;
	logic                   clean_valid;
	logic                   clean_ready = 1'b0;
	htsed_pkg::clean_item_t clean;

	int send_idle_pct = 25;
	int recv_idle_pct = 54;
	int n_errors = 0;
	int text_items = 0;

	// decoder state
	logic [7:0]             ent_buf [SPAN];
	int                     ent_len = 0;
	bit                     in_entity = 0;
	bit                     in_tag = 0;
	logic [7:0]             replay_q [$];
	htsed_pkg::clean_item_t step_out [$];
	htsed_pkg::clean_item_t cleaned_q [$];
	htsed_pkg::clean_item_t got, want_item;

	string      ENTITY_NAMES [NUM_ENTITIES] = '{"amp", "#38", "#39", "apos", "rsquo",
		"lsquo", "quot", "ldquo", "rdquo", "nbsp", "mdash", "ndash", "#8217"};
	logic [7:0] ENTITY_CHARS [NUM_ENTITIES] = '{"&", "&", "'", "'", "'", "'", "\"",
		"\"", "\"", " ", "-", "-", "'"};

	dir_row_t dir_rows [24] = '{
		'{8'h00, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1},
		'{8'h00, 1'b1, 1'b0, 1'b1, 8'h00, 1'b1, 1'b0},
		'{8'hff, 1'b1, 1'b1, 1'b1, 8'hff, 1'b1, 1'b1},
		'{8'h55, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{"&",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{"a",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{"m",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{"p",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{";",   1'b1, 1'b0, 1'b1, htsed_pkg::CH_AMP, 1'b1, 1'b0},
		'{"&",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{";",   1'b1, 1'b0, 1'b1, htsed_pkg::CH_QMARK, 1'b1, 1'b0},
		'{"<",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{"&",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{">",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{"&",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{"<",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{">",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{"&",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{"x",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{"<",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{"1",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{"2",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{"3",   1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0}
	};

	html_tag_strip_entity_decode dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_valid  (text_valid),
		.text_ready  (text_ready),
		.text        (text),
		.clean_valid (clean_valid),
		.clean_ready (clean_ready),
		.clean       (clean)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---- decoder ----
	function automatic void emit_char(input logic [7:0] ch);
		htsed_pkg::clean_item_t r;
		r.out_byte = ch;
		r.out_valid = 1'b1;
		r.last_result = 1'b0;
		if (step_out.size() < SPAN + 1) begin
			step_out.push_back(r);
		end
	endfunction

	function automatic logic [7:0] entity_value();
		bit same;
		for (int i = 0; i < NUM_ENTITIES; i++) begin
			same = (ENTITY_NAMES[i].len() == ent_len);
			for (int j = 0; j < ent_len && same; j++) begin
				if (ent_buf[j] != ENTITY_NAMES[i][j]) begin
					same = 0;
				end
			end
			if (same) begin
				return ENTITY_CHARS[i];
			end
		end
		return htsed_pkg::CH_QMARK;
	endfunction

	function automatic void abort_entity();
		emit_char(htsed_pkg::CH_AMP);
		in_entity = 0;
		for (int j = ent_len - 1; j >= 0; j--) begin
			replay_q.push_front(ent_buf[j]);
		end
		ent_len = 0;
	endfunction

	function automatic void take_byte(input logic [7:0] b);
		if (in_entity) begin
			if (b == htsed_pkg::CH_SEMI) begin
				emit_char(entity_value());
				in_entity = 0;
				ent_len = 0;
			end else begin
				ent_buf[ent_len] = b;
				ent_len++;
				if (ent_len >= SPAN) begin
					abort_entity();
				end
			end
		end else if (in_tag) begin
			if (b == htsed_pkg::CH_GT) begin
				in_tag = 0;
			end
		end else if (b == htsed_pkg::CH_LT) begin
			in_tag = 1;
		end else if (b == htsed_pkg::CH_AMP) begin
			in_entity = 1;
			ent_len = 0;
		end else begin
			emit_char(b);
		end
	endfunction

	function automatic void run_replay();
		while (replay_q.size() > 0) begin
			take_byte(replay_q.pop_front());
		end
	endfunction

	function automatic void predict_cleaned(input htsed_pkg::text_item_t it);
		htsed_pkg::clean_item_t r;
		step_out.delete();
		replay_q.delete();
		if (it.byte_valid) begin
			take_byte(it.text_byte);
			run_replay();
		end
		if (it.end_of_text) begin
			while (in_entity) begin
				abort_entity();
				run_replay();
			end
			in_tag = 0;
			ent_len = 0;
			if (step_out.size() > 0) begin
				step_out[$].last_result = 1'b1;
			end else begin
				r = '0;
				r.last_result = 1'b1;
				step_out.push_back(r);
			end
		end
	endfunction

	// ---- stimulus ----
	task automatic send_item(input htsed_pkg::text_item_t it, input bit typed = 0,
		input htsed_pkg::clean_item_t want = '0);
		text <= it;
		text_valid <= 1'b1;
		do @(posedge clk); while (!text_ready);
		predict_cleaned(it);
		if (typed) begin
			cleaned_q.push_back(want);
		end else begin
			foreach (step_out[i]) cleaned_q.push_back(step_out[i]);
		end
		if ($urandom_range(99) < send_idle_pct) begin
			text_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	function automatic logic [7:0] pick_char();
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: return 8'h61 + 8'($urandom_range(25));
			6: return 8'h30 + 8'($urandom_range(9));
			7: return "#";
			8: return 8'($urandom_range(32, 126));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic send_text();
		logic [7:0] txt [$];
		logic [7:0] c;
		int         nseg, n, k;
		nseg = $urandom_range(6);
		repeat (nseg) begin
			k = $urandom_range(99);
			if (k < 30) begin
				repeat ($urandom_range(1, 4)) txt.push_back(8'($urandom_range(32, 126)));
			end else if (k < 50) begin
				txt.push_back(htsed_pkg::CH_AMP);
				n = $urandom_range(NUM_ENTITIES - 1);
				for (int j = 0; j < ENTITY_NAMES[n].len(); j++)
					txt.push_back(ENTITY_NAMES[n][j]);
				txt.push_back(htsed_pkg::CH_SEMI);
			end else if (k < 65) begin
				txt.push_back(htsed_pkg::CH_AMP);
				repeat ($urandom_range(SPAN - 1)) txt.push_back(pick_char());
				txt.push_back(htsed_pkg::CH_SEMI);
			end else if (k < 75) begin
				txt.push_back(htsed_pkg::CH_AMP);
				repeat ($urandom_range(SPAN, SPAN + 2)) begin
					c = pick_char();
					txt.push_back(c == htsed_pkg::CH_SEMI ? 8'h78 : c);
				end
			end else if (k < 85) begin
				txt.push_back(htsed_pkg::CH_LT);
				repeat ($urandom_range(4)) txt.push_back(pick_char());
				txt.push_back(htsed_pkg::CH_GT);
			end else if (k < 95) begin
				txt.push_back(8'($urandom_range(255)));
			end else begin
				txt.push_back($urandom_range(1) ? htsed_pkg::CH_AMP : htsed_pkg::CH_LT);
				repeat ($urandom_range(3)) txt.push_back(pick_char());
			end
		end
		foreach (txt[i]) begin
			if ($urandom_range(19) == 0) begin
				send_item(htsed_pkg::text_item_t'{8'($urandom_range(255)), 1'b0, 1'b0});
			end
			if (i == txt.size() - 1 && $urandom_range(1)) begin
				send_item(htsed_pkg::text_item_t'{txt[i], 1'b1, 1'b1});
				text_items += txt.size();
				return;
			end
			send_item(htsed_pkg::text_item_t'{txt[i], 1'b1, 1'b0});
		end
		send_item(htsed_pkg::text_item_t'{8'($urandom_range(255)), 1'b0, 1'b1});
		text_items += txt.size() + 1;
	endtask

	always @(posedge clk) begin
		clean_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// ---- checking ----
	always @(posedge clk) begin
		if (arst_n && clean_valid && clean_ready) begin
			got = clean;
			if (cleaned_q.size() == 0) begin
				$error("unexpected transaction out_byte=%h out_valid=%b last_result=%b",
					got.out_byte, got.out_valid, got.last_result);
				n_errors++;
			end else begin
				want_item = cleaned_q.pop_front();
				if (got.out_byte !== want_item.out_byte) begin
					$error("out_byte: expected %h, got %h", want_item.out_byte, got.out_byte);
					n_errors++;
				end
				if (got.out_valid !== want_item.out_valid) begin
					$error("out_valid: expected %b, got %b", want_item.out_valid, got.out_valid);
					n_errors++;
				end
				if (got.last_result !== want_item.last_result) begin
					$error("last_result: expected %b, got %b", want_item.last_result,
						got.last_result);
					n_errors++;
				end
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		foreach (dir_rows[i]) begin
			send_item(htsed_pkg::text_item_t'{dir_rows[i].b, dir_rows[i].v, dir_rows[i].e},
				dir_rows[i].typed,
				htsed_pkg::clean_item_t'{dir_rows[i].wb, dir_rows[i].wv, dir_rows[i].wl});
		end
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 54 : 0;
			recv_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 25 : 0;
			while (text_items < (ph + 1) * 100) send_text();
		end
		text_valid <= 1'b0;
		while (cleaned_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (n_errors == 0 && cleaned_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
design/htsed_pkg.sv
design/htsed_dp.sv
design/htsed_ctrl.sv
design/html_tag_strip_entity_decode.sv
test/html_tag_strip_entity_decode_test.sv
